// ===== sv/g2s_pkg.sv =====
package g2s_pkg;

    localparam int MaxResults = 9;
    localparam logic [7:0] Nul = 8'h00;

    typedef struct packed {
        logic [7:0] in_char;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] sampa_char;
        logic       run_last;
    } out_item_t;

endpackage

// ===== sv/g2s_stream_if.sv =====
interface g2s_stream_if #(
    parameter type payload_t = g2s_pkg::in_item_t
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/grapheme_to_sampa_transcriber.sv =====
// Polish grapheme to SAMPA transcriber. Lower-case cp1250 text comes in one byte per
// transfer on text (payload g2s_pkg::in_item_t); SAMPA bytes leave one per transfer on
// sampa (payload g2s_pkg::out_item_t), run_last marking the final byte caused by an
// input byte. Two bytes of lookahead are held, so output lags by two characters until
// a byte with text_end set flushes everything, with NUL seen past the end, and the
// block starts a new text. An accepted byte is converted in the cycle it is taken and
// its zero to nine result bytes go to a result buffer that drains one byte per cycle,
// save while the receiver holds ready low, through an output register. A new input
// byte is taken once the buffer is empty or its last byte moves out, so no new byte is
// taken before the result bytes of the one before have left the buffer. A text_end
// byte flushing three characters yields up to nine bytes, an ordinary byte up to
// three, and some bytes yield nothing.
module grapheme_to_sampa_transcriber (
    input logic          clk,
    input logic          rst_n,
    g2s_stream_if.sink   text,
    g2s_stream_if.source sampa
);
    import g2s_pkg::*;

    localparam int CntW = $clog2(MaxResults + 1);

    typedef struct packed {
        logic [2:0][7:0] ch;
        logic [1:0]      len;
        logic            skip;
    } conv_t;

    function automatic conv_t convert(
        input logic [7:0] cur,
        input logic [7:0] x,
        input logic [7:0] y,
        input logic [7:0] prev,
        input logic       skip,
        input logic       active
    );
        conv_t r;
        r = '0;
        if (active && !skip)
        begin
            case (cur)
                8'hB9: begin r.ch[0] = "o"; r.ch[1] = "~"; r.len = 2'd2; end
                8'hE6: begin r.ch[0] = "t"; r.ch[1] = "s"; r.ch[2] = "'"; r.len = 2'd3; end
                8'hEA: begin r.ch[0] = "e"; r.ch[1] = "~"; r.len = 2'd2; end
                "h":   begin r.ch[0] = "x"; r.len = 2'd1; end
                8'hB3: begin r.ch[0] = "w"; r.len = 2'd1; end
                8'hF1: begin r.ch[0] = "n"; r.ch[1] = "'"; r.len = 2'd2; end
                8'h9C: begin r.ch[0] = "s"; r.ch[1] = "'"; r.len = 2'd2; end
                8'hF3: begin r.ch[0] = "u"; r.len = 2'd1; end
                "w":   begin r.ch[0] = "v"; r.len = 2'd1; end
                "y":   begin r.ch[0] = "I"; r.len = 2'd1; end
                8'h9F: begin r.ch[0] = "z"; r.ch[1] = "'"; r.len = 2'd2; end
                8'hBF: begin r.ch[0] = "Z"; r.len = 2'd1; end
                "a", "e", "o", "i", "u", "j", "p", "b", "t", "g", "f", "m", "l", "k":
                begin
                    r.ch[0] = cur;
                    r.len = 2'd1;
                end
                "c":
                begin
                    if (x == "z")
                    begin
                        r.ch[0] = "t"; r.ch[1] = "S"; r.len = 2'd2; r.skip = 1'b1;
                    end
                    else if (x == "h")
                    begin
                        r.ch[0] = "x"; r.len = 2'd1; r.skip = 1'b1;
                    end
                    else if (x == "i")
                    begin
                        r.ch[0] = "t"; r.ch[1] = "s"; r.ch[2] = "'"; r.len = 2'd3;
                    end
                    else
                    begin
                        r.ch[0] = "t"; r.ch[1] = "s"; r.len = 2'd2;
                    end
                end
                "d":
                begin
                    if (x == "z")
                    begin
                        r.ch[0] = "d"; r.ch[1] = "z"; r.skip = 1'b1;
                        if (y == "i")
                        begin
                            r.ch[2] = "'"; r.len = 2'd3;
                        end
                        else
                        begin
                            r.len = 2'd2;
                        end
                    end
                    else if (x == 8'h9F)
                    begin
                        r.ch[0] = "d"; r.ch[1] = "z"; r.ch[2] = "'"; r.len = 2'd3;
                        r.skip = 1'b1;
                    end
                    else if (x == 8'hBF)
                    begin
                        r.ch[0] = "d"; r.ch[1] = "Z"; r.len = 2'd2; r.skip = 1'b1;
                    end
                    else
                    begin
                        r.ch[0] = "d"; r.len = 2'd1;
                    end
                end
                "n":
                begin
                    if (x == "k")
                    begin
                        r.ch[0] = "N"; r.len = 2'd1;
                    end
                    else if (x == "i")
                    begin
                        r.ch[0] = "n"; r.ch[1] = "'"; r.len = 2'd2;
                    end
                    else
                    begin
                        r.ch[0] = "n"; r.len = 2'd1;
                    end
                end
                "r":
                begin
                    if (x == "z")
                    begin
                        r.ch[0] = "Z"; r.len = 2'd1; r.skip = 1'b1;
                    end
                    else
                    begin
                        r.ch[0] = "r"; r.len = 2'd1;
                    end
                end
                "s":
                begin
                    if (x == "i")
                    begin
                        r.ch[0] = "s"; r.ch[1] = "'"; r.len = 2'd2;
                    end
                    else if (x == "z")
                    begin
                        r.skip = 1'b1;
                        if (prev == "t")
                        begin
                            r.ch[0] = "_"; r.ch[1] = "S"; r.len = 2'd2;
                        end
                        else
                        begin
                            r.ch[0] = "S"; r.len = 2'd1;
                        end
                    end
                    else
                    begin
                        r.ch[0] = "s"; r.len = 2'd1;
                    end
                end
                "z":
                begin
                    if (x == "i")
                    begin
                        r.ch[0] = "z"; r.ch[1] = "'"; r.len = 2'd2; r.skip = 1'b1;
                    end
                    else
                    begin
                        r.ch[0] = "z"; r.len = 2'd1;
                    end
                end
                ".", "!", "?":
                begin
                    r.ch[0] = "_";
                    r.len = 2'd1;
                end
                default:
                begin
                    r = '0;
                end
            endcase
        end
        return r;
    endfunction

    logic [7:0]      prev_char_reg, prev_char_next;
    logic [7:0]      held_reg [2];
    logic [7:0]      held_next [2];
    logic [1:0]      held_count_reg, held_count_next;
    logic            skip_reg, skip_next;

    logic [7:0]      job_reg [MaxResults];
    logic [7:0]      job_next [MaxResults];
    logic [CntW-1:0] job_cnt_reg, job_cnt_next;

    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_char_reg, out_char_next;
    logic            out_last_reg, out_last_next;

    in_item_t        item;
    out_item_t       result;
    logic            accept;
    logic            move;
    logic [1:0]      cnt;
    logic [1:0]      len;
    logic [7:0]      q0, q1, q2;
    logic            act0, act1, act2;
    conv_t           c0, c1, c2;
    logic [CntW-1:0] total;
    logic [7:0]      packed_bytes [MaxResults];

    assign item = text.payload;
    assign move = (job_cnt_reg != '0) && (!out_valid_reg || sampa.ready);
    assign text.ready = (job_cnt_reg == '0) || ((job_cnt_reg == CntW'(1)) && move);
    assign accept = text.valid && text.ready;

    assign cnt = (held_count_reg == 2'd3) ? 2'd2 : held_count_reg;
    assign len = cnt + 2'd1;
    assign q0 = (cnt == 2'd0) ? item.in_char : held_reg[0];
    assign q1 = (cnt == 2'd0) ? Nul : ((cnt == 2'd1) ? item.in_char : held_reg[1]);
    assign q2 = (cnt == 2'd2) ? item.in_char : Nul;

    assign act0 = item.text_end || (len == 2'd3);
    assign act1 = item.text_end && (len != 2'd1);
    assign act2 = item.text_end && (len == 2'd3);

    assign c0 = convert(q0, q1, q2, prev_char_reg, skip_reg, act0);
    assign c1 = convert(q1, q2, Nul, q0, c0.skip, act1);
    assign c2 = convert(q2, Nul, Nul, q1, c1.skip, act2);

    assign total = CntW'(c0.len) + CntW'(c1.len) + CntW'(c2.len);

    always_comb
    begin
        logic [CntW-1:0] pos;
        logic [CntW-1:0] o1;
        logic [CntW-1:0] o2;
        for (int p = 0; p < MaxResults; p++)
        begin
            pos = CntW'(p);
            o1 = pos - CntW'(c0.len);
            o2 = o1 - CntW'(c1.len);
            if (pos < CntW'(c0.len))
                packed_bytes[p] = c0.ch[pos[1:0]];
            else if (o1 < CntW'(c1.len))
                packed_bytes[p] = c1.ch[o1[1:0]];
            else
                packed_bytes[p] = c2.ch[o2[1:0]];
        end
    end

    always_comb
    begin
        prev_char_next = prev_char_reg;
        held_next = held_reg;
        held_count_next = held_count_reg;
        skip_next = skip_reg;
        if (accept)
        begin
            if (item.text_end)
            begin
                prev_char_next = Nul;
                held_next[0] = Nul;
                held_next[1] = Nul;
                held_count_next = 2'd0;
                skip_next = 1'b0;
            end
            else if (len == 2'd3)
            begin
                prev_char_next = q0;
                skip_next = c0.skip;
                held_next[0] = q1;
                held_next[1] = q2;
                held_count_next = 2'd2;
            end
            else
            begin
                held_next[0] = q0;
                held_next[1] = q1;
                held_count_next = len;
            end
        end
    end

    always_comb
    begin
        job_next = job_reg;
        job_cnt_next = job_cnt_reg;
        if (accept)
        begin
            job_next = packed_bytes;
            job_cnt_next = total;
        end
        else if (move)
        begin
            for (int p = 0; p < MaxResults - 1; p++)
                job_next[p] = job_reg[p + 1];
            job_cnt_next = job_cnt_reg - CntW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            out_char_next = job_reg[0];
            out_last_next = (job_cnt_reg == CntW'(1));
        end
        else if (sampa.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_char_reg <= '0;
            held_reg[0] <= '0;
            held_reg[1] <= '0;
            held_count_reg <= '0;
            skip_reg <= 1'b0;
            job_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_char_reg <= prev_char_next;
            held_reg <= held_next;
            held_count_reg <= held_count_next;
            skip_reg <= skip_next;
            job_cnt_reg <= job_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign result.sampa_char = out_char_reg;
    assign result.run_last = out_last_reg;
    assign sampa.valid = out_valid_reg;
    assign sampa.payload = result;

endmodule
